@@ src/sws_pkg.sv @@
// shared types, constants and helpers for the square wave sound unit
package sws_pkg;

	localparam int unsigned WAVE_DEPTH = 16;
	localparam int unsigned WAVE_AW = $clog2(WAVE_DEPTH);

	localparam int unsigned SDIV_W = 12;
	localparam int unsigned FLEN_W = 17;
	localparam int unsigned CFG_W = 17;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned SCNT_W = 16;
	localparam int unsigned FCNT_W = 18;

	localparam logic [SDIV_W-1:0] SDIV_RESET = 12'd95;
	localparam logic [FLEN_W-1:0] FLEN_RESET = 17'd70224;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DIVIDER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 1'b1;

	localparam logic [6:0] SAMPLE_HIGH = 7'd100;
	localparam logic [7:0] MASTER_ENABLE_RESET = 8'h01;
	localparam logic [11:0] WAVE_PAGE = 12'hFF3;

	localparam logic [15:0] ADDR_SWEEP_ONE = 16'hFF10;
	localparam logic [15:0] ADDR_LENGTH_ONE = 16'hFF11;
	localparam logic [15:0] ADDR_ENVELOPE_ONE = 16'hFF12;
	localparam logic [15:0] ADDR_PITCH_LOW_ONE = 16'hFF13;
	localparam logic [15:0] ADDR_PITCH_HIGH_ONE = 16'hFF14;
	localparam logic [15:0] ADDR_DUTY_TWO = 16'hFF16;
	localparam logic [15:0] ADDR_ENVELOPE_TWO = 16'hFF17;
	localparam logic [15:0] ADDR_PITCH_LOW_TWO = 16'hFF18;
	localparam logic [15:0] ADDR_PITCH_HIGH_TWO = 16'hFF19;
	localparam logic [15:0] ADDR_WAVE_0 = 16'hFF1A;
	localparam logic [15:0] ADDR_WAVE_1 = 16'hFF1B;
	localparam logic [15:0] ADDR_WAVE_2 = 16'hFF1C;
	localparam logic [15:0] ADDR_WAVE_3 = 16'hFF1D;
	localparam logic [15:0] ADDR_WAVE_4 = 16'hFF1E;
	localparam logic [15:0] ADDR_NOISE_0 = 16'hFF20;
	localparam logic [15:0] ADDR_NOISE_1 = 16'hFF21;
	localparam logic [15:0] ADDR_NOISE_2 = 16'hFF22;
	localparam logic [15:0] ADDR_NOISE_3 = 16'hFF23;
	localparam logic [15:0] ADDR_MASTER_0 = 16'hFF24;
	localparam logic [15:0] ADDR_MASTER_1 = 16'hFF25;
	localparam logic [15:0] ADDR_MASTER_2 = 16'hFF26;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_READ  = 2'd1,
		OP_WRITE = 2'd2,
		OP_NOP   = 2'd3
	} opcode_t;

	function automatic logic [7:0] duty_pattern(input logic [1:0] sel);
		logic [7:0] p;
		unique case (sel)
			2'd0: p = 8'h01;
			2'd1: p = 8'h81;
			2'd2: p = 8'h87;
			default: p = 8'h7E;
		endcase
		return p;
	endfunction

	// 4 * (2048 - f) for an 11-bit pitch
	function automatic logic [PERIOD_W-1:0] square_period(input logic [10:0] f);
		logic [11:0] diff;
		diff = 12'd2048 - {1'b0, f};
		return {2'b00, diff, 2'b00};
	endfunction

endpackage

@@ src/square_wave_sound_unit.sv @@
// top level: sound register file, square voice counters and result register
// the result is valid in the cycle after the request is accepted
// throughput: one request per cycle while out_ready holds, set by the single result register
// a request is taken while the result register is empty or being emptied
// reset: state registers clear, enable byte reads 1, sample divider 95,
// frame length 70224, no result pending
module square_wave_sound_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [sws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sws_pkg::CFG_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       opcode,
	input  logic [15:0]                      address,
	input  logic [7:0]                       write_data,
	input  logic [7:0]                       tick_clocks,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       read_data,
	output logic                             bus_error,
	output logic                             sample_valid,
	output logic [6:0]                       sample_value,
	output logic                             frame_end
);
	import sws_pkg::*;

	logic [SDIV_W-1:0] sample_divider_q;
	logic [FLEN_W-1:0] frame_length_q;

	logic [7:0] sweep_one_q, length_one_q, envelope_one_q, pitch_high_one_q;
	logic [1:0] duty_select_q;
	logic [7:0] envelope_two_q, pitch_low_two_q, pitch_high_two_q;
	logic [7:0] wave_regs_q [5];
	logic [7:0] noise_regs_q [4];
	logic [7:0] master_regs_q [3];
	logic [7:0] wave_pattern_q [WAVE_DEPTH];
	logic [PERIOD_W-1:0] period_q;
	logic [2:0] duty_step_q;
	logic [SCNT_W-1:0] sample_cnt_q;
	logic [FCNT_W-1:0] frame_cnt_q;

	logic out_valid_q;
	logic [7:0] read_data_q;
	logic bus_error_q, sample_valid_q, frame_end_q;
	logic [6:0] sample_value_q;

	opcode_t op;
	logic accept;
	logic is_tick, is_read, is_write;
	logic wave_hit;
	logic [WAVE_AW-1:0] wave_idx;

	logic [7:0] rd_val;
	logic rd_err, wr_err;
	logic [PERIOD_W-1:0] period_d;
	logic [2:0] duty_step_d;
	logic [SCNT_W-1:0] sample_sum, sample_cnt_d;
	logic [FCNT_W-1:0] frame_sum, frame_cnt_d;
	logic sv_d, fe_d;
	logic [6:0] sval_d;
	logic [7:0] pattern;

	assign op = opcode_t'(opcode);
	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign is_tick = (op == OP_TICK);
	assign is_read = (op == OP_READ);
	assign is_write = (op == OP_WRITE);
	assign wave_hit = (address[15:4] == WAVE_PAGE);
	assign wave_idx = address[WAVE_AW-1:0];

	// bus read decode
	always_comb begin
		rd_val = '0;
		rd_err = 1'b0;
		if (wave_hit) begin
			rd_val = wave_pattern_q[wave_idx];
		end else begin
			unique case (address)
				ADDR_SWEEP_ONE: rd_val = sweep_one_q;
				ADDR_LENGTH_ONE: rd_val = length_one_q;
				ADDR_ENVELOPE_ONE: rd_val = envelope_one_q;
				ADDR_PITCH_LOW_ONE: rd_val = 8'hFF;
				ADDR_PITCH_HIGH_ONE: rd_val = pitch_high_one_q;
				ADDR_DUTY_TWO: rd_val = {duty_select_q, 6'd0};
				ADDR_ENVELOPE_TWO: rd_val = envelope_two_q;
				ADDR_PITCH_HIGH_TWO: rd_val = pitch_high_two_q;
				ADDR_WAVE_0: rd_val = wave_regs_q[0];
				ADDR_WAVE_1: rd_val = wave_regs_q[1];
				ADDR_WAVE_2: rd_val = wave_regs_q[2];
				ADDR_WAVE_4: rd_val = wave_regs_q[4];
				ADDR_NOISE_0: rd_val = noise_regs_q[0];
				ADDR_NOISE_1: rd_val = noise_regs_q[1];
				ADDR_NOISE_2: rd_val = noise_regs_q[2];
				ADDR_NOISE_3: rd_val = noise_regs_q[3];
				ADDR_MASTER_0: rd_val = master_regs_q[0];
				ADDR_MASTER_1: rd_val = master_regs_q[1];
				ADDR_MASTER_2: rd_val = master_regs_q[2];
				default: rd_err = 1'b1;
			endcase
		end
	end

	// bus write map check
	always_comb begin
		wr_err = 1'b0;
		if (!wave_hit) begin
			unique case (address)
				ADDR_SWEEP_ONE, ADDR_LENGTH_ONE, ADDR_ENVELOPE_ONE, ADDR_PITCH_LOW_ONE,
				ADDR_PITCH_HIGH_ONE, ADDR_DUTY_TWO, ADDR_ENVELOPE_TWO,
				ADDR_PITCH_LOW_TWO, ADDR_PITCH_HIGH_TWO,
				ADDR_WAVE_0, ADDR_WAVE_1, ADDR_WAVE_2, ADDR_WAVE_3, ADDR_WAVE_4,
				ADDR_NOISE_0, ADDR_NOISE_1, ADDR_NOISE_2, ADDR_NOISE_3,
				ADDR_MASTER_0, ADDR_MASTER_1, ADDR_MASTER_2: wr_err = 1'b0;
				default: wr_err = 1'b1;
			endcase
		end
	end

	// tick update
	always_comb begin
		pattern = duty_pattern(duty_select_q);
		if ({8'd0, tick_clocks} > period_q) begin
			period_d = square_period({pitch_high_two_q[2:0], pitch_low_two_q});
			duty_step_d = duty_step_q + 3'd1;
		end else begin
			period_d = period_q - {8'd0, tick_clocks};
			duty_step_d = duty_step_q;
		end
		sample_sum = sample_cnt_q + {8'd0, tick_clocks};
		frame_sum = frame_cnt_q + {10'd0, tick_clocks};
		sample_cnt_d = sample_sum;
		frame_cnt_d = frame_sum;
		sv_d = 1'b0;
		fe_d = 1'b0;
		sval_d = '0;
		if (frame_sum >= {1'b0, frame_length_q}) begin
			sample_cnt_d = '0;
			frame_cnt_d = '0;
			fe_d = 1'b1;
		end else if (sample_sum >= {4'd0, sample_divider_q}) begin
			sample_cnt_d = '0;
			sv_d = 1'b1;
			sval_d = pattern[3'd7 - duty_step_d] ? SAMPLE_HIGH : 7'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_divider_q <= SDIV_RESET;
			frame_length_q <= FLEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SAMPLE_DIVIDER: sample_divider_q <= cfg_data[SDIV_W-1:0];
				CFG_FRAME_LENGTH: frame_length_q <= cfg_data[FLEN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_one_q <= '0;
			length_one_q <= '0;
			envelope_one_q <= '0;
			pitch_high_one_q <= '0;
			duty_select_q <= '0;
			envelope_two_q <= '0;
			pitch_low_two_q <= '0;
			pitch_high_two_q <= '0;
			for (int i = 0; i < 5; i++) wave_regs_q[i] <= '0;
			for (int i = 0; i < 4; i++) noise_regs_q[i] <= '0;
			master_regs_q[0] <= '0;
			master_regs_q[1] <= '0;
			master_regs_q[2] <= MASTER_ENABLE_RESET;
			for (int i = 0; i < WAVE_DEPTH; i++) wave_pattern_q[i] <= '0;
			period_q <= '0;
			duty_step_q <= '0;
			sample_cnt_q <= '0;
			frame_cnt_q <= '0;
		end else if (accept) begin
			if (is_tick) begin
				period_q <= period_d;
				duty_step_q <= duty_step_d;
				sample_cnt_q <= sample_cnt_d;
				frame_cnt_q <= frame_cnt_d;
			end else if (is_write) begin
				if (wave_hit) begin
					wave_pattern_q[wave_idx] <= write_data;
				end else begin
					unique case (address)
						ADDR_SWEEP_ONE: sweep_one_q <= write_data;
						ADDR_LENGTH_ONE: length_one_q <= write_data;
						ADDR_ENVELOPE_ONE: envelope_one_q <= write_data;
						ADDR_PITCH_HIGH_ONE: pitch_high_one_q <= write_data;
						ADDR_DUTY_TWO: duty_select_q <= write_data[7:6];
						ADDR_ENVELOPE_TWO: envelope_two_q <= write_data;
						ADDR_PITCH_LOW_TWO: pitch_low_two_q <= write_data;
						ADDR_PITCH_HIGH_TWO: begin
							pitch_high_two_q <= write_data;
							// trigger reloads from the new pitch
							if (write_data[7])
								period_q <= square_period({write_data[2:0], pitch_low_two_q});
						end
						ADDR_WAVE_0: wave_regs_q[0] <= write_data;
						ADDR_WAVE_1: wave_regs_q[1] <= write_data;
						ADDR_WAVE_2: wave_regs_q[2] <= write_data;
						ADDR_WAVE_3: wave_regs_q[3] <= write_data;
						ADDR_WAVE_4: wave_regs_q[4] <= write_data;
						ADDR_NOISE_0: noise_regs_q[0] <= write_data;
						ADDR_NOISE_1: noise_regs_q[1] <= write_data;
						ADDR_NOISE_2: noise_regs_q[2] <= write_data;
						ADDR_NOISE_3: noise_regs_q[3] <= write_data;
						ADDR_MASTER_0: master_regs_q[0] <= write_data;
						ADDR_MASTER_1: master_regs_q[1] <= write_data;
						ADDR_MASTER_2: master_regs_q[2] <= write_data;
						default: ;
					endcase
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ready) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= is_read ? rd_val : 8'd0;
			bus_error_q <= (is_read && rd_err) || (is_write && wr_err);
			sample_valid_q <= is_tick && sv_d;
			sample_value_q <= is_tick ? sval_d : 7'd0;
			frame_end_q <= is_tick && fe_d;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = read_data_q;
	assign bus_error = bus_error_q;
	assign sample_valid = sample_valid_q;
	assign sample_value = sample_value_q;
	assign frame_end = frame_end_q;

endmodule

@@ dv/square_wave_sound_unit_tb.sv @@
// testbench for the square wave sound unit: directed and random bus and tick requests checked against a predictor
module square_wave_sound_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sws_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam logic [3:0][7:0] DUTY_MASKS = {8'h7E, 8'h87, 8'h81, 8'h01};

	typedef struct packed {
		logic [7:0] read_data;
		logic       bus_error;
		logic       sample_valid;
		logic [6:0] sample_value;
		logic       frame_end;
	} sound_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [1:0]            opcode = OP_NOP;
	logic [15:0]           address = '0;
	logic [7:0]            write_data = '0;
	logic [7:0]            tick_clocks = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            read_data;
	logic                  bus_error;
	logic                  sample_valid;
	logic [6:0]            sample_value;
	logic                  frame_end;

	square_wave_sound_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.address      (address),
		.write_data   (write_data),
		.tick_clocks  (tick_clocks),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.read_data    (read_data),
		.bus_error    (bus_error),
		.sample_valid (sample_valid),
		.sample_value (sample_value),
		.frame_end    (frame_end)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor copy of the block state
	logic [SDIV_W-1:0]   divider_setting;
	logic [FLEN_W-1:0]   frame_setting;
	logic [7:0]          sweep_one, length_one, envelope_one, pitch_high_one, pitch_low_one;
	logic [4:0]          length_two;
	logic [1:0]          duty_select;
	logic [7:0]          envelope_two, pitch_low_two, pitch_high_two;
	logic [7:0]          wave_regs [5];
	logic [7:0]          noise_regs [4];
	logic [7:0]          master_regs [3];
	logic [7:0]          wave_ram [WAVE_DEPTH];
	logic [PERIOD_W-1:0] countdown;
	logic [2:0]          duty_step;
	logic [SCNT_W-1:0]   sample_count;
	logic [FCNT_W-1:0]   frame_count;

	sound_result_t expected_results [$];
	int unsigned   fail_count = 0;
	int unsigned   cycle_count = 0;
	int unsigned   sender_idle_pct = 0;
	int unsigned   receiver_stall_pct = 0;

	function automatic logic [PERIOD_W-1:0] voice_period();
		logic [10:0] pitch;
		pitch = {pitch_high_two[2:0], pitch_low_two};
		return PERIOD_W'(16'd2048 - {5'd0, pitch}) << 2;
	endfunction

	function automatic void clear_voice_state();
		divider_setting = SDIV_RESET;
		frame_setting = FLEN_RESET;
		sweep_one = '0; length_one = '0; envelope_one = '0;
		pitch_high_one = '0; pitch_low_one = '0;
		length_two = '0; duty_select = '0; envelope_two = '0;
		pitch_low_two = '0; pitch_high_two = '0;
		foreach (wave_regs[i]) wave_regs[i] = '0;
		foreach (noise_regs[i]) noise_regs[i] = '0;
		foreach (master_regs[i]) master_regs[i] = '0;
		master_regs[2] = MASTER_ENABLE_RESET;
		foreach (wave_ram[i]) wave_ram[i] = '0;
		countdown = '0;
		duty_step = '0;
		sample_count = '0;
		frame_count = '0;
	endfunction

	function automatic sound_result_t predict_sound_result(opcode_t op, logic [15:0] addr,
			logic [7:0] data, logic [7:0] ticks);
		sound_result_t r;
		r = '0;
		case (op)
			OP_TICK: begin
				if ({8'd0, ticks} > countdown) begin
					countdown = voice_period();
					duty_step = duty_step + 3'd1;
				end else begin
					countdown = countdown - {8'd0, ticks};
				end
				sample_count = sample_count + SCNT_W'(ticks);
				frame_count = frame_count + FCNT_W'(ticks);
				if (frame_count >= FCNT_W'(frame_setting)) begin
					sample_count = '0;
					frame_count = '0;
					r.frame_end = 1'b1;
				end else if (sample_count >= SCNT_W'(divider_setting)) begin
					sample_count = '0;
					r.sample_valid = 1'b1;
					r.sample_value = DUTY_MASKS[duty_select][3'd7 - duty_step] ? SAMPLE_HIGH : 7'd0;
				end
			end
			OP_READ: begin
				if (addr[15:4] == WAVE_PAGE) begin
					r.read_data = wave_ram[addr[WAVE_AW-1:0]];
				end else begin
					case (addr)
						ADDR_SWEEP_ONE:      r.read_data = sweep_one;
						ADDR_LENGTH_ONE:     r.read_data = length_one;
						ADDR_ENVELOPE_ONE:   r.read_data = envelope_one;
						ADDR_PITCH_LOW_ONE:  r.read_data = 8'hFF;
						ADDR_PITCH_HIGH_ONE: r.read_data = pitch_high_one;
						ADDR_DUTY_TWO:       r.read_data = {duty_select, 6'd0};
						ADDR_ENVELOPE_TWO:   r.read_data = envelope_two;
						ADDR_PITCH_HIGH_TWO: r.read_data = pitch_high_two;
						ADDR_WAVE_0:         r.read_data = wave_regs[0];
						ADDR_WAVE_1:         r.read_data = wave_regs[1];
						ADDR_WAVE_2:         r.read_data = wave_regs[2];
						ADDR_WAVE_4:         r.read_data = wave_regs[4];
						ADDR_NOISE_0, ADDR_NOISE_1, ADDR_NOISE_2, ADDR_NOISE_3:
							r.read_data = noise_regs[addr[1:0]];
						ADDR_MASTER_0:       r.read_data = master_regs[0];
						ADDR_MASTER_1:       r.read_data = master_regs[1];
						ADDR_MASTER_2:       r.read_data = master_regs[2];
						default:             r.bus_error = 1'b1;
					endcase
				end
			end
			OP_WRITE: begin
				if (addr[15:4] == WAVE_PAGE) begin
					wave_ram[addr[WAVE_AW-1:0]] = data;
				end else begin
					case (addr)
						ADDR_SWEEP_ONE:      sweep_one = data;
						ADDR_LENGTH_ONE:     length_one = data;
						ADDR_ENVELOPE_ONE:   envelope_one = data;
						ADDR_PITCH_LOW_ONE:  pitch_low_one = data;
						ADDR_PITCH_HIGH_ONE: pitch_high_one = data;
						ADDR_DUTY_TWO: begin
							length_two = data[4:0];
							duty_select = data[7:6];
						end
						ADDR_ENVELOPE_TWO:   envelope_two = data;
						ADDR_PITCH_LOW_TWO:  pitch_low_two = data;
						ADDR_PITCH_HIGH_TWO: begin
							pitch_high_two = data;
							if (data[7]) countdown = voice_period();
						end
						ADDR_WAVE_0:         wave_regs[0] = data;
						ADDR_WAVE_1:         wave_regs[1] = data;
						ADDR_WAVE_2:         wave_regs[2] = data;
						ADDR_WAVE_3:         wave_regs[3] = data;
						ADDR_WAVE_4:         wave_regs[4] = data;
						ADDR_NOISE_0, ADDR_NOISE_1, ADDR_NOISE_2, ADDR_NOISE_3:
							noise_regs[addr[1:0]] = data;
						ADDR_MASTER_0:       master_regs[0] = data;
						ADDR_MASTER_1:       master_regs[1] = data;
						ADDR_MASTER_2:       master_regs[2] = data;
						default:             r.bus_error = 1'b1;
					endcase
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	task automatic issue_request(opcode_t op, logic [15:0] addr, logic [7:0] data,
			logic [7:0] ticks);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		address <= addr;
		write_data <= data;
		tick_clocks <= ticks;
		do @(posedge clk); while (!in_ready);
		expected_results.push_back(predict_sound_result(op, addr, data, ticks));
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SAMPLE_DIVIDER) divider_setting = value[SDIV_W-1:0];
		else frame_setting = value[FLEN_W-1:0];
	endtask

	task automatic apply_settings(int unsigned divider, int unsigned frame);
		wait_for_results();
		write_setting(CFG_SAMPLE_DIVIDER, CFG_W'(divider));
		write_setting(CFG_FRAME_LENGTH, CFG_W'(frame));
	endtask

	task automatic test_reset_values();
		issue_request(OP_READ, ADDR_MASTER_2, 8'h00, 8'h00);
		issue_request(OP_READ, ADDR_PITCH_LOW_ONE, 8'hFF, 8'hFF);
		issue_request(OP_READ, ADDR_PITCH_HIGH_TWO, 8'h00, 8'h00);
		issue_request(OP_TICK, 16'hFFFF, 8'hFF, 8'd0);
	endtask

	task automatic test_bus_map();
		issue_request(OP_WRITE, ADDR_DUTY_TWO, 8'hFF, 8'h00);
		issue_request(OP_READ, ADDR_DUTY_TWO, 8'h00, 8'h00);
		issue_request(OP_READ, ADDR_PITCH_LOW_TWO, 8'h00, 8'h00);
		issue_request(OP_READ, ADDR_WAVE_3, 8'h00, 8'h00);
		issue_request(OP_WRITE, 16'hFF15, 8'h5A, 8'h00);
		issue_request(OP_WRITE, 16'hFF1F, 8'hA5, 8'h00);
		issue_request(OP_READ, 16'hFF27, 8'h00, 8'h00);
		issue_request(OP_WRITE, 16'hFF2F, 8'hFF, 8'h00);
		issue_request(OP_READ, 16'h0000, 8'h00, 8'h00);
		issue_request(OP_WRITE, 16'hFF30, 8'hA5, 8'h00);
		issue_request(OP_WRITE, 16'hFF3F, 8'h5A, 8'h00);
		issue_request(OP_READ, 16'hFF3F, 8'h00, 8'h00);
		issue_request(OP_NOP, 16'hFF30, 8'hFF, 8'hFF);
	endtask

	task automatic test_trigger_and_countdown();
		issue_request(OP_WRITE, ADDR_PITCH_LOW_TWO, 8'hFF, 8'h00);
		// pitch 2047 gives the shortest period
		issue_request(OP_WRITE, ADDR_PITCH_HIGH_TWO, 8'h87, 8'h00);
		issue_request(OP_TICK, 16'h0000, 8'h00, 8'd4);
		issue_request(OP_TICK, 16'h0000, 8'h00, 8'd0);
		issue_request(OP_TICK, 16'h0000, 8'h00, 8'd1);
		issue_request(OP_TICK, 16'h0000, 8'h00, 8'd255);
	endtask

	task automatic test_config_extremes();
		int unsigned k;
		// zero divider and zero frame length
		apply_settings(0, 0);
		for (k = 0; k < 2; k++) issue_request(OP_TICK, 16'h0000, 8'h00, 8'(k * 200));
		apply_settings(0, 131071);
		for (k = 0; k < 3; k++) issue_request(OP_TICK, 16'h0000, 8'h00, 8'(k));
		apply_settings(1, 1);
		issue_request(OP_TICK, 16'h0000, 8'h00, 8'd1);
		apply_settings(4095, 131071);
		issue_request(OP_TICK, 16'h0000, 8'h00, 8'd255);
	endtask

	task automatic random_request(output int unsigned sent);
		logic [15:0] addr;
		logic [7:0]  data;
		int unsigned n;
		int unsigned pick;
		sent = 0;
		if ($urandom_range(99) < 30) begin
			// voice setup followed by a run of ticks
			issue_request(OP_WRITE, ADDR_DUTY_TWO, 8'($urandom), 8'($urandom));
			issue_request(OP_WRITE, ADDR_PITCH_LOW_TWO, 8'($urandom), 8'($urandom));
			data = 8'($urandom);
			data[7] = 1'b1;
			if ($urandom_range(1)) data[2:0] = 3'd7;
			issue_request(OP_WRITE, ADDR_PITCH_HIGH_TWO, data, 8'($urandom));
			sent = 3;
			n = $urandom_range(12, 4);
			repeat (n) begin
				if ($urandom_range(9) == 0)
					issue_request(OP_READ, ADDR_PITCH_HIGH_TWO, 8'($urandom), 8'($urandom));
				else
					issue_request(OP_TICK, 16'($urandom), 8'($urandom),
						$urandom_range(1) ? 8'($urandom) : 8'($urandom_range(8)));
				sent++;
			end
			return;
		end
		pick = $urandom_range(99);
		if (pick < 70) addr = 16'hFF10 + 16'($urandom_range(47));
		else if (pick < 80) addr = ADDR_PITCH_HIGH_TWO;
		else addr = 16'($urandom);
		pick = $urandom_range(99);
		if (pick < 45)
			issue_request(OP_TICK, addr, 8'($urandom),
				$urandom_range(1) ? 8'($urandom) : 8'($urandom_range(8)));
		else if (pick < 65) issue_request(OP_READ, addr, 8'($urandom), 8'($urandom));
		else if (pick < 90) issue_request(OP_WRITE, addr, 8'($urandom), 8'($urandom));
		else issue_request(OP_NOP, addr, 8'($urandom), 8'($urandom));
		sent = 1;
	endtask

	task automatic test_random_traffic();
		int unsigned dividers [8] = '{95, 1, 4095, 0, 200, 17, 60, 4095};
		int unsigned frames [8] = '{70224, 600, 131071, 2000, 0, 1, 5000, 300};
		int unsigned phase;
		int unsigned count;
		int unsigned sent;
		for (phase = 0; phase < 8; phase++) begin
			apply_settings(dividers[phase], frames[phase]);
			case (phase % 4)
				0: begin sender_idle_pct = 0; receiver_stall_pct = 0; end
				1: begin sender_idle_pct = 56; receiver_stall_pct = 0; end
				2: begin sender_idle_pct = 0; receiver_stall_pct = 56; end
				default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
			endcase
			count = 0;
			while (count < 125) begin
				random_request(sent);
				count += sent;
				// hold off until the pipeline is empty now and then
				if ($urandom_range(99) == 0) wait_for_results();
			end
		end
	endtask

	always @(posedge clk) begin
		out_ready <= (receiver_stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= receiver_stall_pct);
	end

	always @(posedge clk) begin : check_results
		sound_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				$error("result with no request outstanding");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (read_data !== want.read_data) begin
					$error("read_data expected %0h got %0h", want.read_data, read_data);
					fail_count++;
				end
				if (bus_error !== want.bus_error) begin
					$error("bus_error expected %0b got %0b", want.bus_error, bus_error);
					fail_count++;
				end
				if (sample_valid !== want.sample_valid) begin
					$error("sample_valid expected %0b got %0b", want.sample_valid, sample_valid);
					fail_count++;
				end
				if (sample_value !== want.sample_value) begin
					$error("sample_value expected %0d got %0d", want.sample_value, sample_value);
					fail_count++;
				end
				if (frame_end !== want.frame_end) begin
					$error("frame_end expected %0b got %0b", want.frame_end, frame_end);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[square_wave_sound_unit] ERROR");
			$finish;
		end
	end

	initial begin
		clear_voice_state();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_bus_map();
		test_trigger_and_countdown();
		test_config_extremes();
		test_random_traffic();
		wait_for_results();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("[square_wave_sound_unit] OK");
		end else begin
			$display("[square_wave_sound_unit] ERROR");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/sws_pkg.sv
src/square_wave_sound_unit.sv
dv/square_wave_sound_unit_tb.sv
